[rtl/fsp_pkg.sv]
// shared types and constants of the fasta stream parser
package fsp_pkg;

  localparam longint unsigned DEF_MAX_LEN     = 64'd16777216;
  localparam int unsigned     DEF_MAX_RECORDS = 65536;
  localparam int unsigned     DEF_HEADER_CAP  = 8192;

  localparam int unsigned ALPHABET = 256;
  localparam int unsigned HIST_AW  = $clog2(ALPHABET);

  localparam int unsigned OQ_DEPTH = 4;

  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] BORDER_RESET = 8'h24;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic REG_BORDER_CHAR = 1'b0;

  typedef enum logic [2:0] {
    K_RESIDUE    = 3'd0,
    K_BORDER     = 3'd1,
    K_HDR_CHAR   = 3'd2,
    K_HDR_CLOSED = 3'd3,
    K_FINAL      = 3'd4,
    K_DROPPED    = 3'd5
  } kind_t;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] position;
    logic [15:0] seq_index;
    logic [7:0]  char_value;
    logic [13:0] header_offset;
    logic [24:0] count_after;
    logic [24:0] total_length;
    logic        last;
  } out_item_t;

endpackage

[rtl/fsp_ram.sv]
// generic single-port-write ram with registered read
module fsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fasta_stream_parser.sv]
// fasta stream parser top level: byte stream in, residue/header/border items out
//
// in channel (in_valid/in_ready/in_data) takes one byte or an end-of-input mark
// per cycle while in_ready is high. each accepted item is decoded in the cycle
// after acceptance, when the histogram ram returns the count of its byte, and its
// results enter a four-entry output queue at the following edge. the first result
// of an item reaches out_data through the decode stage register and the queue.
// throughput is one item per cycle while out_ready is high and each item gives
// at most one result; a '>' that closes a record gives two results and the single
// output port then sets the pace. the histogram read-modify-write uses a one-deep
// forward of the previous write.
// in_ready drops when the queue could not hold the results of the item being
// decoded plus two more, so out_ready low stalls the input after a few items
// and nothing is lost.
// reset (rst, synchronous) empties the pipe and queue, clears all counters,
// marks every histogram entry as zero through per-entry valid bits and sets
// border_char to '$'. end of input clears the counters and histogram, border_char kept.
// the apb port holds border_char at address 0; pready is always high.
module fasta_stream_parser #(
  parameter longint unsigned MAX_LEN     = fsp_pkg::DEF_MAX_LEN,
  parameter int unsigned     MAX_RECORDS = fsp_pkg::DEF_MAX_RECORDS,
  parameter int unsigned     HEADER_CAP  = fsp_pkg::DEF_HEADER_CAP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fsp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fsp_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 64'd1);
  localparam int unsigned REC_W = $clog2(MAX_RECORDS + 1);
  localparam int unsigned HL_W  = $clog2(HEADER_CAP + 1);
  localparam int unsigned AW    = fsp_pkg::HIST_AW;
  localparam int unsigned QP_W  = $clog2(fsp_pkg::OQ_DEPTH);
  localparam int unsigned QC_W  = $clog2(fsp_pkg::OQ_DEPTH + 1);
  localparam int unsigned ALPHABET_N = fsp_pkg::ALPHABET;

  // configuration
  logic [7:0] border_char;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fsp_pkg::REG_BORDER_CHAR) ? {24'd0, border_char} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_char <= fsp_pkg::BORDER_RESET;
    end else if (psel && penable && pwrite && paddr[2] == fsp_pkg::REG_BORDER_CHAR) begin
      border_char <= pwdata[7:0];
    end
  end

  // decode stage register
  logic              s1_valid;
  fsp_pkg::in_item_t s1_item;
  logic              in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
    if (in_fire) begin
      s1_item <= in_data;
    end
  end

  // scalar state
  logic             header_open, header_open_next;
  logic [HL_W-1:0]  header_length, header_length_next;
  logic [LEN_W-1:0] stored_length, stored_length_next;
  logic [REC_W-1:0] record_count, record_count_next;

  // histogram ram, valid bits and forward register
  logic [CNT_W-1:0]    hist_rdata;
  logic                hist_we;
  logic [CNT_W-1:0]    hist_wdata;
  logic [ALPHABET_N-1:0] hist_valid;
  logic                fwd_valid;
  logic [AW-1:0]       fwd_addr;
  logic [CNT_W-1:0]    fwd_data;
  logic                clear;

  fsp_ram #(
    .WIDTH(CNT_W),
    .DEPTH(ALPHABET_N)
  ) u_hist (
    .clk  (clk),
    .we   (hist_we),
    .waddr(s1_item.in_byte),
    .wdata(hist_wdata),
    .raddr(in_data.in_byte),
    .rdata(hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hist_valid <= '0;
    end else if (hist_we) begin
      hist_valid[s1_item.in_byte] <= 1'b1;
    end
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= hist_we;
    end
    fwd_addr <= s1_item.in_byte;
    fwd_data <= hist_wdata;
  end

  logic [CNT_W-1:0] cnt_old, cnt_new;

  always_comb begin
    if (fwd_valid && fwd_addr == s1_item.in_byte) begin
      cnt_old = fwd_data;
    end else if (hist_valid[s1_item.in_byte]) begin
      cnt_old = hist_rdata;
    end else begin
      cnt_old = '0;
    end
  end

  // counts saturate at the store size
  assign cnt_new = (cnt_old != CNT_W'(MAX_LEN)) ? cnt_old + CNT_W'(1) : cnt_old;

  // derived values and output-width views
  logic             room, rec_ok, printable;
  logic [REC_W-1:0] cur_rec, rec_after, cur_after;
  logic [CNT_W-1:0] total;
  logic [63:0]      pos_w, cur_w, cur_after_w, hl_w, cnt_old_w, cnt_new_w, total_w;

  assign room      = stored_length != LEN_W'(MAX_LEN - 64'd1);
  assign rec_ok    = record_count != REC_W'(MAX_RECORDS);
  assign printable = s1_item.in_byte >= fsp_pkg::CH_SPACE &&
                     s1_item.in_byte <= fsp_pkg::CH_TILDE;
  assign cur_rec   = (record_count == '0) ? '0 : record_count - REC_W'(1);
  assign rec_after = rec_ok ? record_count + REC_W'(1) : record_count;
  assign cur_after = rec_after - REC_W'(1);
  assign total     = CNT_W'(stored_length) + CNT_W'(1);

  assign pos_w       = 64'(stored_length);
  assign cur_w       = 64'(cur_rec);
  assign cur_after_w = 64'(cur_after);
  assign hl_w        = 64'(header_length);
  assign cnt_old_w   = 64'(cnt_old);
  assign cnt_new_w   = 64'(cnt_new);
  assign total_w     = 64'(total);

  // decode
  fsp_pkg::out_item_t res0, res1;
  logic [1:0]         n_res;

  always_comb begin
    res0               = '0;
    res1               = '0;
    n_res              = 2'd0;
    header_open_next   = header_open;
    header_length_next = header_length;
    stored_length_next = stored_length;
    record_count_next  = record_count;
    hist_we            = 1'b0;
    hist_wdata         = cnt_new;
    clear              = 1'b0;
    if (s1_valid) begin
      if (s1_item.op == fsp_pkg::OP_END) begin
        res0.kind          = fsp_pkg::K_FINAL;
        res0.position      = pos_w[23:0];
        res0.seq_index     = cur_w[15:0];
        res0.char_value    = border_char;
        res0.total_length  = total_w[24:0];
        res0.last          = 1'b1;
        n_res              = 2'd1;
        clear              = 1'b1;
        header_open_next   = 1'b0;
        header_length_next = '0;
        stored_length_next = '0;
        record_count_next  = '0;
      end else if (s1_item.in_byte == fsp_pkg::CH_GT) begin
        record_count_next  = rec_after;
        header_open_next   = 1'b1;
        header_length_next = HL_W'(1);
        if (rec_ok && record_count != '0 && room) begin
          // close the previous record with a border, then header char 0
          res0.kind          = fsp_pkg::K_BORDER;
          res0.position      = pos_w[23:0];
          res0.seq_index     = cur_w[15:0];
          res0.char_value    = border_char;
          res1.kind          = fsp_pkg::K_HDR_CHAR;
          res1.seq_index     = cur_after_w[15:0];
          res1.char_value    = fsp_pkg::CH_GT;
          res1.last          = 1'b1;
          n_res              = 2'd2;
          stored_length_next = stored_length + LEN_W'(1);
        end else begin
          res0.kind       = fsp_pkg::K_HDR_CHAR;
          res0.seq_index  = cur_after_w[15:0];
          res0.char_value = fsp_pkg::CH_GT;
          res0.last       = 1'b1;
          n_res           = 2'd1;
        end
      end else if (header_open) begin
        if (s1_item.in_byte == fsp_pkg::CH_NL) begin
          res0.kind          = fsp_pkg::K_HDR_CLOSED;
          res0.seq_index     = cur_w[15:0];
          res0.header_offset = hl_w[13:0];
          res0.last          = 1'b1;
          n_res              = 2'd1;
          header_open_next   = 1'b0;
        end else if (header_length != HL_W'(HEADER_CAP) && printable) begin
          res0.kind          = fsp_pkg::K_HDR_CHAR;
          res0.seq_index     = cur_w[15:0];
          res0.char_value    = s1_item.in_byte;
          res0.header_offset = hl_w[13:0];
          res0.last          = 1'b1;
          n_res              = 2'd1;
          header_length_next = header_length + HL_W'(1);
        end
      end else if (s1_item.in_byte != fsp_pkg::CH_NL) begin
        res0.position   = pos_w[23:0];
        res0.seq_index  = cur_w[15:0];
        res0.char_value = s1_item.in_byte;
        res0.last       = 1'b1;
        n_res           = 2'd1;
        if (room) begin
          res0.kind          = fsp_pkg::K_RESIDUE;
          res0.count_after   = cnt_new_w[24:0];
          hist_we            = 1'b1;
          stored_length_next = stored_length + LEN_W'(1);
        end else begin
          // last slot is kept for the final border
          res0.kind        = fsp_pkg::K_DROPPED;
          res0.count_after = cnt_old_w[24:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_open   <= 1'b0;
      header_length <= '0;
      stored_length <= '0;
      record_count  <= '0;
    end else begin
      header_open   <= header_open_next;
      header_length <= header_length_next;
      stored_length <= stored_length_next;
      record_count  <= record_count_next;
    end
  end

  // output queue
  fsp_pkg::out_item_t oq [fsp_pkg::OQ_DEPTH];
  logic [QP_W-1:0]    wr_ptr, rd_ptr;
  logic [QC_W-1:0]    oq_count;
  logic               pop;

  assign out_valid = oq_count != '0;
  assign out_data  = oq[rd_ptr];
  assign pop       = out_valid && out_ready;

  // room for the item in decode plus two more results
  assign in_ready = ({1'b0, oq_count} + {{(QC_W - 1){1'b0}}, n_res}) <=
                    (QC_W + 1)'(fsp_pkg::OQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      oq_count <= '0;
    end else begin
      wr_ptr   <= wr_ptr + QP_W'(n_res);
      rd_ptr   <= rd_ptr + QP_W'(pop);
      oq_count <= oq_count + QC_W'(n_res) - QC_W'(pop);
    end
    if (n_res != 2'd0) begin
      oq[wr_ptr] <= res0;
    end
    if (n_res == 2'd2) begin
      oq[wr_ptr + QP_W'(1)] <= res1;
    end
  end

endmodule
